// ===== sv/clr_pkg.sv =====
// Shared constants and types for the command line recognizer.
package clr_pkg;

   // Sizing of the line buffer, token capture and name table.
   localparam int LINE_DEPTH  = 128;
   localparam int MAX_TOKENS  = 8;
   localparam int NAME_CHARS  = 8;
   localparam int NUM_ENTRIES = 4;

   localparam int LEN_W      = $clog2(LINE_DEPTH);
   localparam int NAME_W     = 8 * NAME_CHARS;
   localparam int TOKIDX_W   = $clog2(NAME_CHARS);
   localparam int TOKLEN_W   = $clog2(NAME_CHARS + 2);
   localparam int MAX_PARAMS = (MAX_TOKENS - 1 < 7) ? MAX_TOKENS - 1 : 7;
   localparam int RUNS_SAT   = MAX_PARAMS + 2;
   localparam int RUNS_W     = $clog2(RUNS_SAT + 1);
   localparam int ENTRY_W    = $clog2(NUM_ENTRIES);

   // Character codes.
   localparam logic [7:0] CH_CR       = 8'd13;
   localparam logic [7:0] CH_BS       = 8'd8;
   localparam logic [7:0] CH_SPACE    = 8'd32;
   localparam logic [7:0] CH_UPPER_A  = 8'd65;
   localparam logic [7:0] CH_UPPER_Z  = 8'd90;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_COUNT = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // Register map: index is the byte address divided by eight.
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam logic [2:0] REG_NAME0  = 3'd0;
   localparam logic [2:0] REG_NAME1  = 3'd1;
   localparam logic [2:0] REG_NAME2  = 3'd2;
   localparam logic [2:0] REG_NAME3  = 3'd3;
   localparam logic [2:0] REG_COUNTS = 3'd4;

   // Register reset values.
   localparam logic [63:0] NAME0_RESET  = 64'd1886152040;
   localparam logic [63:0] NAME1_RESET  = 64'd1868983913;
   localparam logic [63:0] NAME2_RESET  = 64'd1953069157;
   localparam logic [63:0] NAME3_RESET  = 64'd7173491;
   localparam logic [15:0] COUNTS_RESET = 16'd8192;

endpackage

// ===== sv/command_line_recognizer.sv =====
// Top level of the command line recognizer: line buffer, walk sequencer and name matcher.
// An ordinary character or backspace word is taken while ready stays high. A return holds
// ready low while the line is walked through the registered read port, for the trim step,
// while the table entries are compared one at a time until a hit or the last entry, and
// while the output register is loaded, longer while a result word waits.
// Reset clears the line length, sequencer, output valid and registers to their defaults.
module command_line_recognizer
   import clr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input channel; tdata: [7:0] data_byte.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   // Result channel; tdata: [1:0] status, [3:2] command_index, [6:4] param_count, [7] zero.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WALK  = 5'b00010,
      ST_TRIM  = 5'b00100,
      ST_MATCH = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // Configuration registers.
   logic [63:0] name_ff [NUM_ENTRIES];
   logic [15:0] counts_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         name_ff[0] <= NAME0_RESET;
         name_ff[1] <= NAME1_RESET;
         name_ff[2] <= NAME2_RESET;
         name_ff[3] <= NAME3_RESET;
         counts_ff  <= COUNTS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_NAME0:  name_ff[0] <= csr_pwdata;
            REG_NAME1:  name_ff[1] <= csr_pwdata;
            REG_NAME2:  name_ff[2] <= csr_pwdata;
            REG_NAME3:  name_ff[3] <= csr_pwdata;
            REG_COUNTS: counts_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_NAME0:  csr_prdata = name_ff[0];
         REG_NAME1:  csr_prdata = name_ff[1];
         REG_NAME2:  csr_prdata = name_ff[2];
         REG_NAME3:  csr_prdata = name_ff[3];
         REG_COUNTS: csr_prdata = {48'd0, counts_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // Sequencer and walk registers.
   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    walk_addr_ff, walk_addr_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [7:0]          rd_data_ff;
   logic                zero_seen_ff, zero_seen_in;
   logic                in_token_ff, in_token_in;
   logic                in_space_ff, in_space_in;
   logic                nonempty_ff, nonempty_in;
   logic [TOKLEN_W-1:0] tok_len_ff, tok_len_in;
   logic [RUNS_W-1:0]   runs_ff, runs_in;
   logic [ENTRY_W-1:0]  entry_ff, entry_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic [ENTRY_W-1:0]  res_index_ff, res_index_in;
   logic [2:0]          res_count_ff, res_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [6:0]          rsp_data_ff, rsp_data_in;
   logic [7:0]          tok_bytes_ff [NAME_CHARS];

   logic [7:0]          char_folded;
   logic                req_fire;
   logic                mem_we;
   logic                mem_re;
   logic                tok_clear;
   logic                tok_we;
   logic                rd_hit;
   logic                byte_zero;
   logic                char_ok;
   logic [NAME_W-1:0]   tok_word;
   logic [NAME_W-1:0]   cur_name;
   logic                name_hit;
   logic [3:0]          expect_cnt;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // Fold upper-case letters to lower case.
   always_comb begin
      char_folded = req_tdata;
      if (req_tdata >= CH_UPPER_A && req_tdata <= CH_UPPER_Z) begin
         char_folded = req_tdata + CASE_OFFSET;
      end
   end

   // Stored byte seen this cycle during the walk.
   assign rd_hit    = rd_valid_ff && !zero_seen_ff;
   assign byte_zero = rd_hit && (rd_data_ff == 8'd0);
   assign char_ok   = rd_hit && (rd_data_ff != 8'd0);
   assign mem_re    = (state_ff == ST_WALK) && (walk_addr_ff < len_ff) &&
                      !zero_seen_ff && !byte_zero;
   assign mem_we    = req_fire && (char_folded != CH_BS) && (char_folded != CH_CR) &&
                      (len_ff < LEN_W'(LINE_DEPTH - 1));
   assign tok_clear = req_fire && (char_folded == CH_CR);
   assign tok_we    = (state_ff == ST_WALK) && char_ok && in_token_ff &&
                      (rd_data_ff != CH_SPACE) && (tok_len_ff < TOKLEN_W'(NAME_CHARS));

   // Token as a packed word, first character lowest, for the shared comparator.
   always_comb begin
      for (int b = 0; b < NAME_CHARS; b++) begin
         tok_word[8*b +: 8] = tok_bytes_ff[b];
      end
   end

   assign cur_name   = name_ff[entry_ff][NAME_W-1:0];
   assign name_hit   = (tok_len_ff <= TOKLEN_W'(NAME_CHARS)) && (cur_name != '0) &&
                       (cur_name == tok_word);
   assign expect_cnt = counts_ff[{entry_ff, 2'b00} +: 4];

   // Next-state logic of the sequencer.
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      walk_addr_in  = walk_addr_ff;
      rd_valid_in   = 1'b0;
      zero_seen_in  = zero_seen_ff;
      in_token_in   = in_token_ff;
      in_space_in   = in_space_ff;
      nonempty_in   = nonempty_ff;
      tok_len_in    = tok_len_ff;
      runs_in       = runs_ff;
      entry_in      = entry_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      // The output register empties when the consumer takes the word.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (char_folded == CH_BS) begin
                  if (len_ff != '0) begin
                     len_in = len_ff - LEN_W'(1);
                  end
               end else if (char_folded == CH_CR) begin
                  state_in     = ST_WALK;
                  walk_addr_in = '0;
                  zero_seen_in = 1'b0;
                  in_token_in  = 1'b1;
                  in_space_in  = 1'b0;
                  nonempty_in  = 1'b0;
                  tok_len_in   = '0;
                  runs_in      = '0;
               end else if (mem_we) begin
                  len_in = len_ff + LEN_W'(1);
               end
            end
         end
         ST_WALK: begin
            rd_valid_in = mem_re;
            if (mem_re) begin
               walk_addr_in = walk_addr_ff + LEN_W'(1);
            end
            if (byte_zero) begin
               zero_seen_in = 1'b1;
            end
            if (char_ok) begin
               nonempty_in = 1'b1;
               if (rd_data_ff == CH_SPACE) begin
                  in_token_in = 1'b0;
                  in_space_in = 1'b1;
                  if (!in_space_ff && runs_ff < RUNS_W'(RUNS_SAT)) begin
                     runs_in = runs_ff + RUNS_W'(1);
                  end
               end else begin
                  in_space_in = 1'b0;
                  if (in_token_ff && tok_len_ff <= TOKLEN_W'(NAME_CHARS)) begin
                     tok_len_in = tok_len_ff + TOKLEN_W'(1);
                  end
               end
            end
            if (!rd_valid_ff && !mem_re) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // A trailing run of spaces starts no parameter.
            if (in_space_ff) begin
               runs_in = runs_ff - RUNS_W'(1);
            end
            len_in   = '0;
            entry_in = '0;
            state_in = nonempty_ff ? ST_MATCH : ST_IDLE;
         end
         ST_MATCH: begin
            res_count_in = (runs_ff > RUNS_W'(7)) ? 3'd7 : runs_ff[2:0];
            if (name_hit) begin
               res_index_in = entry_ff;
               if (runs_ff > RUNS_W'(MAX_PARAMS) || runs_ff != expect_cnt) begin
                  res_status_in = STATUS_BAD_COUNT;
               end else begin
                  res_status_in = STATUS_OK;
               end
               state_in = ST_EMIT;
            end else if (entry_ff == ENTRY_W'(NUM_ENTRIES - 1)) begin
               res_index_in  = '0;
               res_status_in = STATUS_NOT_FOUND;
               state_in      = ST_EMIT;
            end else begin
               entry_in = entry_ff + ENTRY_W'(1);
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_count_ff, res_index_ff, res_status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk and result payload registers.
   always_ff @(posedge clock) begin
      walk_addr_ff  <= walk_addr_in;
      zero_seen_ff  <= zero_seen_in;
      in_token_ff   <= in_token_in;
      in_space_ff   <= in_space_in;
      nonempty_ff   <= nonempty_in;
      tok_len_ff    <= tok_len_in;
      runs_ff       <= runs_in;
      entry_ff      <= entry_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_count_ff  <= res_count_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Token capture: cleared on a return, filled while the first token is walked.
   always_ff @(posedge clock) begin
      if (tok_clear) begin
         for (int b = 0; b < NAME_CHARS; b++) begin
            tok_bytes_ff[b] <= 8'd0;
         end
      end else if (tok_we) begin
         tok_bytes_ff[tok_len_ff[TOKIDX_W-1:0]] <= rd_data_ff;
      end
   end

   // Line memory with one write port and a registered read port.
   logic [7:0] line_mem [LINE_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[len_ff] <= char_folded;
      end
      if (mem_re) begin
         rd_data_ff <= line_mem[walk_addr_ff];
      end
   end

endmodule

// ===== sv/clr_checker.sv =====
// Port-level checker for the command line recognizer and its bind statement.
module clr_checker
   import clr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // No result word is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Only the three defined status codes appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("undefined status code");

   // A name that was not found reports entry zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == STATUS_NOT_FOUND |-> rsp_tdata[3:2] == 2'd0)
      else $error("not found with nonzero index");

   // Only a return word starts a result; an ordinary character never does next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata != CH_CR |=> !$rose(rsp_tvalid))
      else $error("result after ordinary character");

endmodule

bind command_line_recognizer clr_checker u_clr_checker (.*);
